/* rtl/core/i2c_master_byte_engine_top_defines.svh */
// ---------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Shared concurrent assertion forms. The clock is clk and the asynchronous
// active-low reset is rst_n in every module that uses them.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH

// Condition holds at every edge outside reset
`define I2C_ME_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define I2C_ME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define I2C_ME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/i2c_me_pkg.sv */
// ---------------------------------------------------------------------------
// I2C master byte engine package
// Shared widths, codes and the queue word carried from front to back end.
// ---------------------------------------------------------------------------
`default_nettype none

package i2c_me_pkg;

    localparam int DELAY_W             = 16;
    localparam int BYTE_W              = 8;
    localparam int BIT_CNT_W           = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [DELAY_W-1:0]   DELAY_RESET   = 16'd4;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Bus command codes as seen on the opcode field
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    // Tick class after decode
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    // One decoded tick in the queue
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] write_data;
        logic              send_ack;
        logic              sda_in;
    } tick_word_t;

endpackage

`default_nettype wire

/* rtl/core/i2c_me_if.sv */
// ---------------------------------------------------------------------------
// I2C master byte engine channels
// Tick input channel, result output channel and delay configuration channel.
// ---------------------------------------------------------------------------
`default_nettype none

// Tick channel: one word per timing tick
interface i2c_me_tick_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd_valid;
    logic [1:0]                     opcode;
    logic [i2c_me_pkg::BYTE_W-1:0]  write_data;
    logic                           send_ack;
    logic                           sda_in;

    modport source (output valid, cmd_valid, opcode, write_data, send_ack, sda_in,
                    input ready);
    modport sink   (input valid, cmd_valid, opcode, write_data, send_ack, sda_in,
                    output ready);
endinterface

// Result channel: one word per tick
interface i2c_me_result_if;
    logic                           valid;
    logic                           ready;
    logic                           scl_out;
    logic                           sda_out;
    logic                           busy_res;
    logic                           done_res;
    logic [i2c_me_pkg::BYTE_W-1:0]  read_data;
    logic                           ack_error;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_error, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_error, output ready);
endinterface

// Configuration channel: delay_ticks write data
interface i2c_me_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [i2c_me_pkg::DELAY_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/i2c_me_front.sv */
// ---------------------------------------------------------------------------
// I2C master byte engine front end
// Accepts tick words and classifies them into queue words.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_me_front (
    i2c_me_tick_if.sink             tick,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output i2c_me_pkg::tick_word_t  push_word
);

    i2c_me_pkg::opcode_t op;

    // Handshake passes straight into the queue
    assign push_valid = tick.valid;
    assign tick.ready = push_ready;
    assign op         = i2c_me_pkg::opcode_t'(tick.opcode);

    // Classify the tick
    always_comb
    begin
        push_word.write_data = tick.write_data;
        push_word.send_ack   = tick.send_ack;
        push_word.sda_in     = tick.sda_in;
        if (!tick.cmd_valid)
        begin
            push_word.kind = i2c_me_pkg::KIND_NONE;
        end
        else
        begin
            unique case (op)
                i2c_me_pkg::OP_START: push_word.kind = i2c_me_pkg::KIND_START;
                i2c_me_pkg::OP_STOP:  push_word.kind = i2c_me_pkg::KIND_STOP;
                i2c_me_pkg::OP_WRITE: push_word.kind = i2c_me_pkg::KIND_WRITE;
                i2c_me_pkg::OP_READ:  push_word.kind = i2c_me_pkg::KIND_READ;
                default:              push_word.kind = i2c_me_pkg::KIND_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/i2c_me_queue.sv */
// ---------------------------------------------------------------------------
// I2C master byte engine queue
// Short register FIFO between front and back end. DEPTH must be 2 or more.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_top_defines.svh"

module i2c_me_queue #(
    parameter int DEPTH = i2c_me_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  i2c_me_pkg::tick_word_t  push_word,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output i2c_me_pkg::tick_word_t  pop_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    i2c_me_pkg::tick_word_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push_fire, pop_fire;

    // Status and head word
    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    `I2C_ME_ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_CNT, "queue count over depth")
    `I2C_ME_ASSERT_NEXT(a_count_inc, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1, "queue count did not rise on push")
    `I2C_ME_ASSERT_NEXT(a_count_dec, pop_fire && !push_fire, count_reg == $past(count_reg) - 1'b1, "queue count did not fall on pop")

endmodule

`default_nettype wire

/* rtl/core/i2c_me_back.sv */
// ---------------------------------------------------------------------------
// I2C master byte engine back end
// Bus segment sequencer and result output register, one tick per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_top_defines.svh"

module i2c_me_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  i2c_me_pkg::tick_word_t  pop_word,
    i2c_me_cfg_if.sink              cfg,
    i2c_me_result_if.source         result
);

    localparam int DW = i2c_me_pkg::DELAY_W;
    localparam int BW = i2c_me_pkg::BYTE_W;
    localparam int NW = i2c_me_pkg::BIT_CNT_W;

    // Bus segments
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_HIGH  = 4'd1,
        PH_ST_SDA   = 4'd2,
        PH_ST_SCL   = 4'd3,
        PH_WBIT_LO  = 4'd5,
        PH_WBIT_HI  = 4'd6,
        PH_WACK_LO  = 4'd7,
        PH_WACK_HI  = 4'd8,
        PH_WEND     = 4'd9,
        PH_RBIT_HI  = 4'd10,
        PH_RBIT_LO  = 4'd11,
        PH_TAIL_LO  = 4'd12,
        PH_TAIL_SDA = 4'd13,
        PH_TAIL_HI  = 4'd14,
        PH_TAIL_END = 4'd15
    } phase_t;

    typedef struct packed {
        logic scl;
        logic sda;
    } lv_t;

    // Line levels on entry to a segment
    function automatic lv_t enter_lv(phase_t p, lv_t cur, logic msb, logic bc_zero,
                                     logic is_stop, logic ack);
        lv_t lv;
        lv = cur;
        unique case (p)
            PH_ST_HIGH:  begin lv.scl = 1'b1; lv.sda = 1'b1; end
            PH_ST_SDA:   lv.sda = 1'b0;
            PH_ST_SCL:   lv.scl = 1'b0;
            PH_WBIT_LO:  begin lv.scl = 1'b0; lv.sda = msb; end
            PH_WBIT_HI:  lv.scl = 1'b1;
            PH_WACK_LO:  begin lv.scl = 1'b0; lv.sda = 1'b1; end
            PH_WACK_HI:  lv.scl = 1'b1;
            PH_WEND:     lv.scl = 1'b0;
            PH_RBIT_HI:
            begin
                lv.scl = 1'b1;
                if (bc_zero)
                begin
                    lv.sda = 1'b1;
                end
            end
            PH_RBIT_LO:  lv.scl = 1'b0;
            PH_TAIL_LO:  lv.scl = 1'b0;
            PH_TAIL_SDA: lv.sda = is_stop ? 1'b0 : !ack;
            PH_TAIL_HI:  lv.scl = 1'b1;
            PH_TAIL_END:
            begin
                if (!is_stop)
                begin
                    lv.scl = 1'b0;
                end
                lv.sda = 1'b1;
            end
            default: ;
        endcase
        return lv;
    endfunction

    phase_t              phase_reg, phase_next;
    logic [NW-1:0]       bit_count_reg, bit_count_next;
    logic [DW-1:0]       delay_count_reg, delay_count_next;
    logic [BW-1:0]       shift_reg, shift_next;
    i2c_me_pkg::opcode_t op_reg, op_next;
    logic                ack_choice_reg, ack_choice_next;
    lv_t                 lv_reg, lv_next;
    logic                ack_fail_reg, ack_fail_next;
    logic [BW-1:0]       rx_reg, rx_next;
    logic [DW-1:0]       delay_ticks_reg;

    logic                res_valid_reg;
    lv_t                 res_lv_reg, res_lv_next;
    logic                res_busy_reg, res_busy_next;
    logic                res_done_reg, res_done_next;

    logic                step_en;
    logic [DW:0]         len_w;
    logic [DW:0]         dc_inc;

    // One tick steps when the output register is free or being drained
    assign pop_ready = !res_valid_reg || result.ready;
    assign step_en   = pop_valid && pop_ready;
    assign cfg.ready = 1'b1;

    // A delay of zero acts as one
    assign len_w  = (delay_ticks_reg == '0) ? (DW+1)'(1) : {1'b0, delay_ticks_reg};
    assign dc_inc = {1'b0, delay_count_reg} + (DW+1)'(1);

    // Sequencer step for the tick at the queue head
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        delay_count_next = delay_count_reg;
        shift_next       = shift_reg;
        op_next          = op_reg;
        ack_choice_next  = ack_choice_reg;
        lv_next          = lv_reg;
        ack_fail_next    = ack_fail_reg;
        rx_next          = rx_reg;
        res_busy_next    = 1'b0;
        res_done_next    = 1'b0;

        // Command start, only while idle
        if (phase_reg == PH_IDLE && pop_word.kind != i2c_me_pkg::KIND_NONE)
        begin
            bit_count_next   = '0;
            delay_count_next = '0;
            unique case (pop_word.kind)
                i2c_me_pkg::KIND_START:
                begin
                    op_next    = i2c_me_pkg::OP_START;
                    phase_next = PH_ST_HIGH;
                end
                i2c_me_pkg::KIND_STOP:
                begin
                    op_next    = i2c_me_pkg::OP_STOP;
                    phase_next = PH_TAIL_LO;
                end
                i2c_me_pkg::KIND_WRITE:
                begin
                    op_next    = i2c_me_pkg::OP_WRITE;
                    shift_next = pop_word.write_data;
                    phase_next = PH_WBIT_LO;
                end
                i2c_me_pkg::KIND_READ:
                begin
                    op_next         = i2c_me_pkg::OP_READ;
                    shift_next      = '0;
                    ack_choice_next = pop_word.send_ack;
                    phase_next      = PH_RBIT_HI;
                end
                default: ;
            endcase
            lv_next = enter_lv(phase_next, lv_next, shift_next[BW-1],
                               bit_count_next == '0, op_next == i2c_me_pkg::OP_STOP,
                               ack_choice_next);
        end

        // Levels shown on this tick
        res_lv_next = lv_next;

        // Segment timing and advance
        if (phase_next != PH_IDLE)
        begin
            res_busy_next = 1'b1;
            if (dc_inc >= len_w)
            begin
                delay_count_next = '0;
                unique case (phase_next)
                    PH_ST_HIGH:  phase_next = PH_ST_SDA;
                    PH_ST_SDA:   phase_next = PH_ST_SCL;
                    PH_WBIT_LO:  phase_next = PH_WBIT_HI;
                    PH_WBIT_HI:
                    begin
                        shift_next     = {shift_next[BW-2:0], 1'b0};
                        bit_count_next = bit_count_next + 1'b1;
                        phase_next     = (bit_count_next >= i2c_me_pkg::BITS_PER_BYTE) ?
                                         PH_WACK_LO : PH_WBIT_LO;
                    end
                    PH_WACK_LO:  phase_next = PH_WACK_HI;
                    PH_WACK_HI:
                    begin
                        ack_fail_next = pop_word.sda_in;
                        phase_next    = PH_WEND;
                    end
                    PH_RBIT_HI:
                    begin
                        shift_next = {shift_next[BW-2:0], pop_word.sda_in};
                        phase_next = PH_RBIT_LO;
                    end
                    PH_RBIT_LO:
                    begin
                        bit_count_next = bit_count_next + 1'b1;
                        if (bit_count_next >= i2c_me_pkg::BITS_PER_BYTE)
                        begin
                            rx_next    = shift_next;
                            phase_next = PH_TAIL_LO;
                        end
                        else
                        begin
                            phase_next = PH_RBIT_HI;
                        end
                    end
                    PH_TAIL_LO:  phase_next = PH_TAIL_SDA;
                    PH_TAIL_SDA: phase_next = PH_TAIL_HI;
                    PH_TAIL_HI:  phase_next = PH_TAIL_END;
                    default:
                    begin
                        // Last segment of start, write or read/stop tail
                        phase_next    = PH_IDLE;
                        res_done_next = 1'b1;
                    end
                endcase
                lv_next = enter_lv(phase_next, lv_next, shift_next[BW-1],
                                   bit_count_next == '0, op_next == i2c_me_pkg::OP_STOP,
                                   ack_choice_next);
            end
            else
            begin
                delay_count_next = dc_inc[DW-1:0];
            end
        end
    end

    // State, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            delay_count_reg <= '0;
            shift_reg       <= '0;
            op_reg          <= i2c_me_pkg::OP_START;
            ack_choice_reg  <= 1'b0;
            lv_reg          <= '{scl: 1'b1, sda: 1'b1};
            ack_fail_reg    <= 1'b0;
            rx_reg          <= '0;
            delay_ticks_reg <= i2c_me_pkg::DELAY_RESET;
            res_valid_reg   <= 1'b0;
            res_lv_reg      <= '{scl: 1'b1, sda: 1'b1};
            res_busy_reg    <= 1'b0;
            res_done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                delay_ticks_reg <= cfg.data;
            end
            if (step_en)
            begin
                phase_reg       <= phase_next;
                bit_count_reg   <= bit_count_next;
                delay_count_reg <= delay_count_next;
                shift_reg       <= shift_next;
                op_reg          <= op_next;
                ack_choice_reg  <= ack_choice_next;
                lv_reg          <= lv_next;
                ack_fail_reg    <= ack_fail_next;
                rx_reg          <= rx_next;
                res_valid_reg   <= 1'b1;
                res_lv_reg      <= res_lv_next;
                res_busy_reg    <= res_busy_next;
                res_done_reg    <= res_done_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result word; read_data and ack_error track the committed state
    assign result.valid     = res_valid_reg;
    assign result.scl_out   = res_lv_reg.scl;
    assign result.sda_out   = res_lv_reg.sda;
    assign result.busy_res  = res_busy_reg;
    assign result.done_res  = res_done_reg;
    assign result.read_data = rx_reg;
    assign result.ack_error = ack_fail_reg;

    `I2C_ME_ASSERT_SAME(a_delay_bound, phase_reg != PH_IDLE, {1'b0, delay_count_reg} < len_w, "delay count past segment length")
    `I2C_ME_ASSERT_ALWAYS(a_bit_bound, bit_count_reg <= i2c_me_pkg::BITS_PER_BYTE, "bit count past one byte")
    `I2C_ME_ASSERT_SAME(a_done_idle, res_valid_reg && res_done_reg, res_busy_reg && phase_reg == PH_IDLE, "done without busy or idle return")
    `I2C_ME_ASSERT_NEXT(a_stall_hold, res_valid_reg && !result.ready, $stable(phase_reg) && $stable(delay_count_reg), "sequencer moved while result stalled")

endmodule

`default_nettype wire

/* rtl/core/i2c_master_byte_engine_top.sv */
// ---------------------------------------------------------------------------
// I2C master byte engine top level
// Bit-level I2C master: start, stop, byte write and byte read sequences.
// ---------------------------------------------------------------------------
// Every tick word is one bus timing tick and gives exactly one result word.
// The engine takes one tick per clock cycle when the result side keeps up;
// that rate is set by the segment sequencer in the back end, which performs
// one tick step per cycle. A tick is written into the front-to-back queue
// when it is taken and is stepped from the queue head into the output
// register, from which its result word is driven on the result port.
// Each bus segment lasts delay_ticks ticks (zero acts as one). Commands that
// arrive while a sequence runs are ignored. Write delay_ticks only while idle.
`default_nettype none

module i2c_master_byte_engine_top #(
    parameter int QUEUE_DEPTH = i2c_me_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    i2c_me_tick_if.sink      tick,
    i2c_me_result_if.source  result,
    i2c_me_cfg_if.sink       cfg
);

    logic                   push_valid;
    logic                   push_ready;
    i2c_me_pkg::tick_word_t push_word;
    logic                   pop_valid;
    logic                   pop_ready;
    i2c_me_pkg::tick_word_t pop_word;

    // Decode ticks
    i2c_me_front u_front (
        .tick       (tick),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    // Decouple front and back
    i2c_me_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    // Run bus segments
    i2c_me_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .cfg       (cfg),
        .result    (result)
    );

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives one tick word per handshake into the engine and checks every result
// word against a cycle-free model of the segment sequencer. A short table of
// directed commands comes first (reset levels, NACK/ACK, 0x00/0xFF bytes,
// commands while busy), then random start/byte/stop transfers with random SDA
// samples over several delay settings, including zero and a long segment.
// ----------------------------------------------------------------------------

module testbench;

    import i2c_me_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    // Bus segments of the engine, in sequencer order
    typedef enum logic [3:0] {
        SEG_IDLE        = 4'd0,
        SEG_ST_HIGH     = 4'd1,
        SEG_ST_SDA_LOW  = 4'd2,
        SEG_ST_SCL_LOW  = 4'd3,
        SEG_WR_LOW      = 4'd5,
        SEG_WR_HIGH     = 4'd6,
        SEG_WR_ACK_LOW  = 4'd7,
        SEG_WR_ACK_HIGH = 4'd8,
        SEG_WR_END      = 4'd9,
        SEG_RD_HIGH     = 4'd10,
        SEG_RD_LOW      = 4'd11,
        SEG_TAIL_LOW    = 4'd12,
        SEG_TAIL_SDA    = 4'd13,
        SEG_TAIL_HIGH   = 4'd14,
        SEG_TAIL_END    = 4'd15
    } seg_t;

    // Result-side stall patterns
    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct packed {
        logic              cmd_valid;
        opcode_t           op;
        logic [BYTE_W-1:0] wdata;
        logic              sack;
        logic              sda;
    } tick_in_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rdata;
        logic              ack_err;
    } bus_word_t;

    typedef struct {
        tick_in_t  cmd;
        logic      fill_sda;
        bit        fill_cmd;
        bit        typed;
        bus_word_t typed_word;
    } step_row_t;

    localparam bus_word_t NO_WORD = '0;

    logic clk = 1'b0;
    logic rst_n;

    i2c_me_tick_if   tick_ch ();
    i2c_me_result_if res_ch ();
    i2c_me_cfg_if    cfg_ch ();

    i2c_master_byte_engine_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Engine model state
    // ------------------------------------------------------------------
    seg_t                 seg;
    logic [BIT_CNT_W-1:0] bits_done;
    logic [DELAY_W-1:0]   seg_ticks;
    logic [BYTE_W-1:0]    shreg;
    opcode_t              cur_op;
    logic                 ack_sel;
    logic                 scl_q;
    logic                 sda_q;
    logic                 ack_err_q;
    logic [BYTE_W-1:0]    rx_byte;
    logic [DELAY_W-1:0]   delay_cfg;

    bus_word_t bus_words_due [$];
    int unsigned ticks_sent;
    int unsigned errors;
    int unsigned stuck_cycles;

    // Driver-side tag for the word on the tick channel
    bit        drv_typed;
    bus_word_t drv_word;

    // Sender pacing
    int unsigned burst_left;

    function automatic void enter_seg(input seg_t s);
        seg = s;
        seg_ticks = '0;
        case (s)
            SEG_ST_HIGH:     begin sda_q = 1'b1; scl_q = 1'b1; end
            SEG_ST_SDA_LOW:  sda_q = 1'b0;
            SEG_ST_SCL_LOW:  scl_q = 1'b0;
            SEG_WR_LOW:      begin scl_q = 1'b0; sda_q = shreg[BYTE_W-1]; end
            SEG_WR_HIGH:     scl_q = 1'b1;
            SEG_WR_ACK_LOW:  begin scl_q = 1'b0; sda_q = 1'b1; end
            SEG_WR_ACK_HIGH: scl_q = 1'b1;
            SEG_WR_END:      scl_q = 1'b0;
            SEG_RD_HIGH:
            begin
                scl_q = 1'b1;
                // SDA is released on the first read bit only
                if (bits_done == '0)
                    sda_q = 1'b1;
            end
            SEG_RD_LOW:      scl_q = 1'b0;
            SEG_TAIL_LOW:    scl_q = 1'b0;
            SEG_TAIL_SDA:    sda_q = (cur_op == OP_STOP) ? 1'b0 : !ack_sel;
            SEG_TAIL_HIGH:   scl_q = 1'b1;
            SEG_TAIL_END:
            begin
                if (cur_op != OP_STOP)
                    scl_q = 1'b0;
                sda_q = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Segment boundary: sample where needed, move on; 1 when the sequence ends
    function automatic bit end_seg(input logic sda);
        case (seg)
            SEG_ST_HIGH:    enter_seg(SEG_ST_SDA_LOW);
            SEG_ST_SDA_LOW: enter_seg(SEG_ST_SCL_LOW);
            SEG_WR_LOW:     enter_seg(SEG_WR_HIGH);
            SEG_WR_HIGH:
            begin
                shreg = shreg << 1;
                bits_done = bits_done + 1'b1;
                if (bits_done >= BITS_PER_BYTE)
                    enter_seg(SEG_WR_ACK_LOW);
                else
                    enter_seg(SEG_WR_LOW);
            end
            SEG_WR_ACK_LOW: enter_seg(SEG_WR_ACK_HIGH);
            SEG_WR_ACK_HIGH:
            begin
                ack_err_q = sda;
                enter_seg(SEG_WR_END);
            end
            SEG_RD_HIGH:
            begin
                shreg = {shreg[BYTE_W-2:0], sda};
                enter_seg(SEG_RD_LOW);
            end
            SEG_RD_LOW:
            begin
                bits_done = bits_done + 1'b1;
                if (bits_done >= BITS_PER_BYTE)
                begin
                    rx_byte = shreg;
                    enter_seg(SEG_TAIL_LOW);
                end
                else
                    enter_seg(SEG_RD_HIGH);
            end
            SEG_TAIL_LOW:   enter_seg(SEG_TAIL_SDA);
            SEG_TAIL_SDA:   enter_seg(SEG_TAIL_HIGH);
            SEG_TAIL_HIGH:  enter_seg(SEG_TAIL_END);
            default:
            begin
                seg = SEG_IDLE;
                seg_ticks = '0;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // One tick of the engine: returns the bus word it produces
    function automatic bus_word_t engine_tick(input tick_in_t t);
        bus_word_t   w;
        int unsigned seg_len;
        w = '0;
        if (seg == SEG_IDLE && t.cmd_valid)
        begin
            cur_op = t.op;
            bits_done = '0;
            case (t.op)
                OP_START: enter_seg(SEG_ST_HIGH);
                OP_STOP:  enter_seg(SEG_TAIL_LOW);
                OP_WRITE:
                begin
                    shreg = t.wdata;
                    enter_seg(SEG_WR_LOW);
                end
                default:
                begin
                    shreg = '0;
                    ack_sel = t.sack;
                    enter_seg(SEG_RD_HIGH);
                end
            endcase
        end
        w.scl = scl_q;
        w.sda = sda_q;
        if (seg != SEG_IDLE)
        begin
            w.busy = 1'b1;
            // zero delay counts as one tick per segment
            seg_len = (delay_cfg == '0) ? 32'd1 : 32'(delay_cfg);
            if (32'(seg_ticks) + 32'd1 >= seg_len)
                w.done = end_seg(t.sda);
            else
                seg_ticks = seg_ticks + 1'b1;
        end
        w.rdata = rx_byte;
        w.ack_err = ack_err_q;
        return w;
    endfunction

    function automatic void report_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: config writes, accepted ticks, result words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bus_word_t got;
        bus_word_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                delay_cfg = cfg_ch.data;
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.scl_out, res_ch.sda_out, res_ch.busy_res, res_ch.done_res,
                       res_ch.read_data, res_ch.ack_error};
                if (bus_words_due.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = bus_words_due.pop_front();
                    report_field("scl_out", 8'(want.scl), 8'(got.scl));
                    report_field("sda_out", 8'(want.sda), 8'(got.sda));
                    report_field("busy_res", 8'(want.busy), 8'(got.busy));
                    report_field("done_res", 8'(want.done), 8'(got.done));
                    report_field("read_data", want.rdata, got.rdata);
                    report_field("ack_error", 8'(want.ack_err), 8'(got.ack_err));
                end
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                want = engine_tick({tick_ch.cmd_valid, opcode_t'(tick_ch.opcode),
                                    tick_ch.write_data, tick_ch.send_ack, tick_ch.sda_in});
                bus_words_due.push_back(drv_typed ? drv_word : want);
                ticks_sent++;
            end
        end
    end

    // Watchdog: no handshake of any kind for too long
    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d words outstanding",
                     $time, STUCK_LIMIT, bus_words_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Result-side ready: random stall patterns, each held for a random stretch
    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;
    int unsigned rx_cycle = 0;

    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(64, 512);
        end
        else
            rx_left--;
        case (rx_mode)
            RX_OPEN:  res_ch.ready <= 1'b1;
            RX_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: res_ch.ready <= ($urandom_range(0, 4) < 2);
            default:  res_ch.ready <= (rx_cycle % 3 != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (all start and end at a falling edge)
    // ------------------------------------------------------------------
    function automatic bus_word_t bus(input logic scl, input logic sda, input logic busy,
                                      input logic done, input logic [7:0] rdata,
                                      input logic ack_err);
        return {scl, sda, busy, done, rdata, ack_err};
    endfunction

    function automatic step_row_t row(input bit cv, input opcode_t op, input logic [7:0] d,
                                      input bit sack, input bit sda, input bit fsda,
                                      input bit fcmd, input bit typed, input bus_word_t w);
        step_row_t r;
        r.cmd = {cv, op, d, sack, sda};
        r.fill_sda = fsda;
        r.fill_cmd = fcmd;
        r.typed = typed;
        r.typed_word = w;
        return r;
    endfunction

    function automatic tick_in_t idle_tick();
        tick_in_t t;
        t.cmd_valid = 1'b0;
        t.op = opcode_t'($urandom_range(0, 3));
        t.wdata = BYTE_W'($urandom_range(0, 255));
        t.sack = 1'($urandom_range(0, 1));
        t.sda = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // Send one tick word; random bursts with gaps between them
    task automatic send_tick(input tick_in_t t, input bit typed = 1'b0,
                             input bus_word_t w = NO_WORD);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        tick_ch.valid      <= 1'b1;
        tick_ch.cmd_valid  <= t.cmd_valid;
        tick_ch.opcode     <= t.op;
        tick_ch.write_data <= t.wdata;
        tick_ch.send_ack   <= t.sack;
        tick_ch.sda_in     <= t.sda;
        drv_typed          <= typed;
        drv_word           <= w;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        @(negedge clk);
    endtask

    // Feed ticks until the running sequence has ended
    task automatic run_to_idle(input bit rand_sda, input bit level, input bit allow_cmd);
        tick_in_t t;
        while (seg != SEG_IDLE)
        begin
            t = idle_tick();
            if (!rand_sda)
                t.sda = level;
            // commands while busy must be ignored
            if (allow_cmd && $urandom_range(0, 2) == 0)
                t.cmd_valid = 1'b1;
            send_tick(t);
        end
    endtask

    task automatic issue_cmd(input opcode_t op, input logic [7:0] d, input bit sack);
        tick_in_t t;
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) send_tick(idle_tick());
        t = idle_tick();
        t.cmd_valid = 1'b1;
        t.op = op;
        t.wdata = d;
        t.sack = sack;
        send_tick(t);
        run_to_idle(1'b1, 1'b0, 1'b1);
    endtask

    // Hold off the sender until every expected word has come back
    task automatic drain();
        tick_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (bus_words_due.size() != 0);
    endtask

    task automatic set_delay(input logic [DELAY_W-1:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed transfers; some lone commands and idle noise
    task automatic run_transfer();
        int unsigned kind;
        kind = $urandom_range(0, 19);
        if (kind == 0)
            drain();
        if (kind < 15)
        begin
            issue_cmd(OP_START, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 1))
                    issue_cmd(OP_WRITE, BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                else
                    issue_cmd(OP_READ, BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
            // now and then a transfer is left open
            if ($urandom_range(0, 9) != 0)
                issue_cmd(OP_STOP, BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
        else if (kind < 18)
            issue_cmd(opcode_t'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        else
            repeat ($urandom_range(1, 8)) send_tick(idle_tick());
    endtask

    task automatic random_ticks(input int unsigned n);
        int unsigned stop_at;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at)
            run_transfer();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    step_row_t step_rows [$];

    initial
    begin
        rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.cmd_valid = 1'b0;
        tick_ch.opcode = OP_START;
        tick_ch.write_data = '0;
        tick_ch.send_ack = 1'b0;
        tick_ch.sda_in = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        drv_typed = 1'b0;
        drv_word = NO_WORD;
        burst_left = 0;
        ticks_sent = 0;
        errors = 0;
        stuck_cycles = 0;

        seg = SEG_IDLE;
        bits_done = '0;
        seg_ticks = '0;
        shreg = '0;
        cur_op = OP_START;
        ack_sel = 1'b0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        ack_err_q = 1'b0;
        rx_byte = '0;
        delay_cfg = DELAY_RESET;

        // cmd op data ack sda | fill sda, fill cmd | typed word
        step_rows.push_back(row(0, OP_START, 8'h00, 0, 0, 0, 0, 1, bus(1, 1, 0, 0, 8'h00, 0)));
        step_rows.push_back(row(0, OP_READ, 8'hFF, 1, 1, 0, 0, 1, bus(1, 1, 0, 0, 8'h00, 0)));
        step_rows.push_back(row(1, OP_START, 8'h00, 0, 1, 1, 0, 1, bus(1, 1, 1, 0, 8'h00, 0)));
        step_rows.push_back(row(0, OP_STOP, 8'h00, 0, 0, 0, 0, 1, bus(0, 0, 0, 0, 8'h00, 0)));
        // NACKed write of all ones, commands thrown at it while busy
        step_rows.push_back(row(1, OP_WRITE, 8'hFF, 0, 0, 1, 1, 1, bus(0, 1, 1, 0, 8'h00, 0)));
        step_rows.push_back(row(0, OP_START, 8'h00, 0, 0, 0, 0, 1, bus(0, 1, 0, 0, 8'h00, 1)));
        // ACKed write of all zeros
        step_rows.push_back(row(1, OP_WRITE, 8'h00, 0, 0, 0, 0, 1, bus(0, 0, 1, 0, 8'h00, 1)));
        step_rows.push_back(row(0, OP_START, 8'h00, 0, 1, 0, 0, 1, bus(0, 1, 0, 0, 8'h00, 0)));
        // read 0xFF with ACK, then 0x00 with NACK
        step_rows.push_back(row(1, OP_READ, 8'h00, 1, 1, 1, 0, 1, bus(1, 1, 1, 0, 8'h00, 0)));
        step_rows.push_back(row(0, OP_START, 8'h00, 0, 0, 0, 0, 1, bus(0, 1, 0, 0, 8'hFF, 0)));
        step_rows.push_back(row(1, OP_READ, 8'hFF, 0, 0, 0, 1, 0, NO_WORD));
        step_rows.push_back(row(0, OP_START, 8'h00, 0, 0, 0, 0, 1, bus(0, 1, 0, 0, 8'h00, 0)));
        step_rows.push_back(row(1, OP_STOP, 8'h00, 0, 0, 0, 0, 1, bus(0, 1, 1, 0, 8'h00, 0)));
        step_rows.push_back(row(0, OP_START, 8'h00, 0, 0, 0, 0, 1, bus(1, 1, 0, 0, 8'h00, 0)));
        step_rows.push_back(row(1, OP_START, 8'h00, 0, 0, 1, 1, 0, NO_WORD));
        step_rows.push_back(row(1, OP_WRITE, 8'hA5, 1, 1, 0, 0, 0, NO_WORD));
        step_rows.push_back(row(1, OP_WRITE, 8'h5A, 0, 0, 1, 1, 0, NO_WORD));
        step_rows.push_back(row(1, OP_READ, 8'h3C, 1, 0, 0, 0, 0, NO_WORD));
        step_rows.push_back(row(1, OP_READ, 8'hC3, 0, 1, 1, 1, 0, NO_WORD));
        step_rows.push_back(row(1, OP_STOP, 8'hFF, 1, 1, 1, 0, 0, NO_WORD));
        step_rows.push_back(row(1, OP_STOP, 8'h00, 0, 0, 0, 1, 0, NO_WORD));
        step_rows.push_back(row(0, OP_READ, 8'hFF, 1, 1, 0, 0, 0, NO_WORD));

        // reset held from the start, released at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at the reset delay
        foreach (step_rows[i])
        begin
            send_tick(step_rows[i].cmd, step_rows[i].typed, step_rows[i].typed_word);
            if (step_rows[i].cmd.cmd_valid)
                run_to_idle(1'b0, step_rows[i].fill_sda, step_rows[i].fill_cmd);
        end

        // random transfers across delay settings
        set_delay(16'd1);
        random_ticks(200);
        set_delay(16'd0);
        random_ticks(150);
        // long segments: a single start condition only
        set_delay(16'd40);
        issue_cmd(OP_START, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        set_delay(16'd2);
        random_ticks(150);
        set_delay(16'd3);
        random_ticks(100);
        set_delay(DELAY_W'($urandom_range(1, 6)));
        random_ticks(75);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
